// File: hdl/rarst_pkg.sv
package rarst_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int PTR_W        = IDX_W + 2;
    localparam int SUM_W        = 64;
    localparam int VAL_W        = 32;
    localparam int PROD_W       = VAL_W + CNT_W + 1;
    localparam int WORD_W       = 2 * SUM_W;

    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam int S_TDATA_W = ((2 * IDX_W + VAL_W + 7) / 8) * 8;

endpackage

// File: hdl/rarst_ram.sv
module rarst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: hdl/range_add_range_sum_tree_unit.sv
// Range add / range sum over up to 1024 signed 64-bit elements, all zero after reset.
// Internally two Fenwick trees (difference values and index-weighted difference values)
// share one 1024 x 128 memory; each operation walks two tree paths with a read step and
// a write or accumulate step per node, at most 21 nodes for an add and 19 for a query,
// which then adds multiply and finish steps. The input is not ready again until the item
// is done, but a query's sum then waits in an output register, so the next word can be
// taken while it is pending. After reset the memory is swept to zero, during which no
// word is accepted.
// A query delivers one 64-bit wrapping sum; an add delivers nothing. Empty or
// out-of-range spans add nothing and query as zero. element_count clips ranges only.
module range_add_range_sum_tree_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wen,
    input  logic [rarst_pkg::CNT_W-1:0]     i_cfg_wdata,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // range_low, range_high, add_value, zero pad
    input  logic [rarst_pkg::S_TDATA_W-1:0] i_s_tdata,
    // kind
    input  logic                            i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // range_sum
    output logic [rarst_pkg::SUM_W-1:0]     o_m_tdata
);

    localparam int IW = rarst_pkg::IDX_W;
    localparam int CW = rarst_pkg::CNT_W;
    localparam int PW = rarst_pkg::PTR_W;
    localparam int SW = rarst_pkg::SUM_W;
    localparam int VW = rarst_pkg::VAL_W;
    localparam int MW = rarst_pkg::PROD_W;

    typedef enum logic [2:0] {
        ST_CLR, ST_IDLE, ST_PREP, ST_RD, ST_WR, ST_MUL, ST_FIN, ST_OUT
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_count;
    logic [IW:0]     r_clr;
    logic            r_kind;
    logic            r_pass;
    logic [IW-1:0]   r_lo;
    logic [IW-1:0]   r_hi;
    logic [VW-1:0]   r_v;
    logic [PW-1:0]   r_idx;
    logic [SW-1:0]   r_d1;
    logic [SW-1:0]   r_d2;
    logic [SW-1:0]   r_p1;
    logic [SW-1:0]   r_p2;
    logic [SW-1:0]   r_prod;
    logic [SW-1:0]   r_sb;
    logic [SW-1:0]   r_sum;
    logic            r_mv;
    logic [SW-1:0]   r_mdata;

    logic [IW-1:0]   w_a;
    logic [IW-1:0]   w_b;
    logic [CW-1:0]   w_n;
    logic [CW-1:0]   w_bclip;
    logic            w_empty;
    logic [CW-1:0]   w_j;
    logic [CW-1:0]   w_f;
    logic [MW-1:0]   w_vj;
    logic [SW-1:0]   w_vs;
    logic [SW-1:0]   w_vjs;
    logic [PW-1:0]   w_low;
    logic [SW-1:0]   w_s;
    logic [2*SW-1:0] w_rdata;
    logic            w_we;
    logic [IW-1:0]   w_waddr;
    logic [2*SW-1:0] w_wdata;
    logic [IW-1:0]   w_raddr;
    logic            w_done;
    logic            w_load;

    assign w_a = i_s_tdata[IW-1:0];
    assign w_b = i_s_tdata[2*IW-1:IW];
    assign w_n = (r_count > CW'(rarst_pkg::MAX_ELEMENTS)) ?
                 CW'(rarst_pkg::MAX_ELEMENTS) : r_count;
    assign w_empty = (w_n == '0) || (w_a > w_b) || ({1'b0, w_a} >= w_n);
    assign w_bclip = ({1'b0, w_b} > (w_n - CW'(1))) ? (w_n - CW'(1)) : {1'b0, w_b};

    // element index of the update point, or tree index of the prefix end for queries
    assign w_j = r_pass ? ({1'b0, r_hi} + CW'(1)) : {1'b0, r_lo};
    assign w_f = r_pass ? {1'b0, r_lo} : ({1'b0, r_hi} + CW'(1));
    assign w_vj = MW'($signed({{(MW-VW){r_v[VW-1]}}, r_v}) * $signed({{(MW-CW){1'b0}}, w_j}));
    assign w_vs = {{(SW-VW){r_v[VW-1]}}, r_v};
    assign w_vjs = {{(SW-MW){w_vj[MW-1]}}, w_vj};
    assign w_low = r_idx & (~r_idx + PW'(1));
    assign w_s = r_prod - r_p2;
    assign w_done = (r_kind == rarst_pkg::KIND_ADD) ?
                    (r_idx > PW'(rarst_pkg::MAX_ELEMENTS)) : (r_idx == '0);

    assign w_raddr = IW'(r_idx - PW'(1));
    assign w_we = (r_state == ST_CLR) ||
                  ((r_state == ST_WR) && (r_kind == rarst_pkg::KIND_ADD));
    assign w_waddr = (r_state == ST_CLR) ? r_clr[IW-1:0] : w_raddr;
    assign w_wdata = (r_state == ST_CLR) ? '0 :
                     {w_rdata[2*SW-1:SW] + r_d2, w_rdata[SW-1:0] + r_d1};

    rarst_ram #(
        .WIDTH (2 * SW),
        .DEPTH (rarst_pkg::MAX_ELEMENTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_load     = (r_state == ST_OUT) && (!r_mv || i_m_tready);
    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_mv;
    assign o_m_tdata  = r_mdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_count <= CW'(rarst_pkg::MAX_ELEMENTS);
            r_clr   <= '0;
            r_pass  <= 1'b0;
            r_mv    <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_count <= i_cfg_wdata;
            end
            if (w_load) begin
                r_mv    <= 1'b1;
                r_mdata <= r_sum;
            end else if (i_m_tready) begin
                r_mv <= 1'b0;
            end
            case (r_state)
                ST_CLR: begin
                    r_clr <= r_clr + (IW+1)'(1);
                    if (r_clr == (IW+1)'(rarst_pkg::MAX_ELEMENTS - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_s_tvalid) begin
                        r_kind <= i_s_tuser;
                        r_lo   <= w_a;
                        r_hi   <= w_bclip[IW-1:0];
                        r_v    <= i_s_tdata[2*IW+VW-1:2*IW];
                        r_pass <= 1'b0;
                        if (w_empty) begin
                            r_sum <= '0;
                            if (i_s_tuser == rarst_pkg::KIND_QUERY) begin
                                r_state <= ST_OUT;
                            end
                        end else begin
                            r_state <= ST_PREP;
                        end
                    end
                end
                ST_PREP: begin
                    r_p1 <= '0;
                    r_p2 <= '0;
                    if (r_kind == rarst_pkg::KIND_ADD) begin
                        r_idx <= {1'b0, w_j} + PW'(1);
                        r_d1  <= r_pass ? (SW'(0) - w_vs) : w_vs;
                        r_d2  <= r_pass ? (SW'(0) - w_vjs) : w_vjs;
                    end else begin
                        r_idx <= {1'b0, w_f};
                    end
                    r_state <= ST_RD;
                end
                ST_RD: begin
                    if (w_done) begin
                        if (r_kind == rarst_pkg::KIND_QUERY) begin
                            r_state <= ST_MUL;
                        end else if (r_pass) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_pass  <= 1'b1;
                            r_state <= ST_PREP;
                        end
                    end else begin
                        r_state <= ST_WR;
                    end
                end
                ST_WR: begin
                    if (r_kind == rarst_pkg::KIND_ADD) begin
                        r_idx <= r_idx + w_low;
                    end else begin
                        r_p1  <= r_p1 + w_rdata[SW-1:0];
                        r_p2  <= r_p2 + w_rdata[2*SW-1:SW];
                        r_idx <= r_idx - w_low;
                    end
                    r_state <= ST_RD;
                end
                ST_MUL: begin
                    r_prod  <= SW'(r_p1 * {{(SW-CW){1'b0}}, w_f});
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    if (r_pass) begin
                        r_sum   <= r_sb - w_s;
                        r_state <= ST_OUT;
                    end else begin
                        r_sb    <= w_s;
                        r_pass  <= 1'b1;
                        r_state <= ST_PREP;
                    end
                end
                ST_OUT: begin
                    if (w_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: hdl/rarst_chk.sv
module rarst_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_s_tready,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [rarst_pkg::SUM_W-1:0]     o_m_tdata
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result word dropped or changed while stalled");

    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown({o_s_tready, o_m_tvalid}))
        else $error("handshake outputs unknown");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && !o_s_tready)
        else $error("active after reset");

endmodule

bind range_add_range_sum_tree_unit rarst_chk u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
